// File: hdl/tsbt_pkg.sv
package tsbt_pkg;

   localparam int NUM_SLOTS = 2;
   localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 30;

   localparam int NS_PER_SAMPLE_W = 20;
   localparam int SLOT_LENGTH_W = 30;
   localparam int CACH_LEAD_W = 16;
   localparam int CORRECTION_W = 16;

   // (cach + correction) fits 18 bits signed, times a 21-bit non-negative factor
   localparam int LEAD_SUM_W = 18;
   localparam int LEAD_PROD_W = LEAD_SUM_W + NS_PER_SAMPLE_W + 1;

   localparam logic [NS_PER_SAMPLE_W-1:0] NS_PER_SAMPLE_RST = 20'd41667;
   localparam logic [SLOT_LENGTH_W-1:0] SLOT_LENGTH_RST = 30'd30000000;
   localparam logic [CACH_LEAD_W-1:0] CACH_LEAD_RST = 16'd60;
   localparam logic [CORRECTION_W-1:0] CORRECTION_RST = 16'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NS_PER_SAMPLE = 3'd0,
      CSR_SLOT_LENGTH = 3'd1,
      CSR_CACH_LEAD = 3'd2,
      CSR_CORRECTION = 3'd3,
      CSR_DIRECT_MODE = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      MODE_RESET = 3'd0,
      MODE_LOAD = 3'd1,
      MODE_ADD = 3'd2,
      MODE_CAPTURE = 3'd3,
      MODE_REQUEST = 3'd4,
      MODE_TRANSMIT = 3'd5
   } mode_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [63:0] value;
      logic [1:0] slot;
   } req_type;

   typedef struct packed {
      logic [63:0] current_time;
      logic [63:0] burst_time;
      logic slot_synced;
      logic [1:0] ready_slot;
      logic transmit_on;
   } rsp_type;

   typedef struct packed {
      logic [NS_PER_SAMPLE_W-1:0] ns_per_sample;
      logic [SLOT_LENGTH_W-1:0] slot_length_ns;
      logic [CACH_LEAD_W-1:0] cach_lead_samples;
      logic signed [CORRECTION_W-1:0] correction_samples;
      logic direct_mode;
   } cfg_type;

endpackage

// File: hdl/tsbt_csr.sv
module tsbt_csr (
   input logic clock,
   input logic reset,
   input logic csr_write_en,
   input logic [tsbt_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [tsbt_pkg::CSR_DATA_W-1:0] csr_write_data,
   output tsbt_pkg::cfg_type cfg
);

   tsbt_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ns_per_sample <= tsbt_pkg::NS_PER_SAMPLE_RST;
         cfg_ff.slot_length_ns <= tsbt_pkg::SLOT_LENGTH_RST;
         cfg_ff.cach_lead_samples <= tsbt_pkg::CACH_LEAD_RST;
         cfg_ff.correction_samples <= tsbt_pkg::CORRECTION_RST;
         cfg_ff.direct_mode <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            tsbt_pkg::CSR_NS_PER_SAMPLE:
               cfg_ff.ns_per_sample <= csr_write_data[tsbt_pkg::NS_PER_SAMPLE_W-1:0];
            tsbt_pkg::CSR_SLOT_LENGTH:
               cfg_ff.slot_length_ns <= csr_write_data[tsbt_pkg::SLOT_LENGTH_W-1:0];
            tsbt_pkg::CSR_CACH_LEAD:
               cfg_ff.cach_lead_samples <= csr_write_data[tsbt_pkg::CACH_LEAD_W-1:0];
            tsbt_pkg::CSR_CORRECTION:
               cfg_ff.correction_samples <= csr_write_data[tsbt_pkg::CORRECTION_W-1:0];
            tsbt_pkg::CSR_DIRECT_MODE:
               cfg_ff.direct_mode <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/tdma_slot_burst_timer.sv
// two-slot tdma time base and transmit burst scheduler
//
// req channel: one transaction per command (mode, value, slot); accepted on a
// clock edge with req_valid high and req_stall low. rsp channel: exactly one
// transaction per command, in order, with the current time after the command,
// the burst time for a request, the timing-ready mark and the transmit flag.
// csr port: plain writes, to be made only while no command is in flight; not enforced.
//
// a command's result passes three registers: timer update, 64x20 time product
// split into two 32x20 multipliers, final sum and slot/burst update.
// throughput: one per cycle while the receiver does not stall.
// timer and count are updated at accept; captures, flags and the burst time
// are updated when the result is loaded, so order is always kept.
//
// reset clears the timer, captures, burst time, flags and the pipeline, and
// loads the register defaults. when the receiver stalls, the result holds and
// the pipeline fills its empty stages; req_stall rises once all are full.
module tdma_slot_burst_timer (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input tsbt_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output tsbt_pkg::rsp_type rsp_data,
   input logic csr_write_en,
   input logic [tsbt_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [tsbt_pkg::CSR_DATA_W-1:0] csr_write_data
);

   tsbt_pkg::cfg_type cfg;

   tsbt_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .cfg(cfg)
   );

   // pipeline control
   logic en_out, en_s2, en_s1, accept;
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;

   assign en_out = !rsp_valid_ff || !rsp_stall;
   assign en_s2 = !s2_valid_ff || en_out;
   assign en_s1 = !s1_valid_ff || en_s2;
   assign accept = req_valid && en_s1;
   assign req_stall = !en_s1;

   // timer state, updated at accept
   logic [63:0] time_base_ff, time_base_in;
   logic [63:0] sample_count_ff, sample_count_in;

   always_comb begin
      time_base_in = time_base_ff;
      sample_count_in = sample_count_ff;
      case (req_data.mode)
         tsbt_pkg::MODE_RESET: begin
            time_base_in = 64'd0;
            sample_count_in = 64'd0;
         end
         tsbt_pkg::MODE_LOAD: begin
            time_base_in = req_data.value;
            sample_count_in = 64'd0;
         end
         tsbt_pkg::MODE_ADD: begin
            sample_count_in = sample_count_ff + req_data.value;
         end
         default: ;
      endcase
   end

   // stage 1
   logic [2:0] s1_mode_ff;
   logic [1:0] s1_slot_ff;
   logic s1_bit_ff;
   logic [63:0] s1_base_ff;
   logic [63:0] s1_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_base_ff <= 64'd0;
         sample_count_ff <= 64'd0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            time_base_ff <= time_base_in;
            sample_count_ff <= sample_count_in;
         end
         if (en_s1) begin
            s1_valid_ff <= req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff <= req_data.mode;
         s1_slot_ff <= req_data.slot;
         s1_bit_ff <= req_data.value[0];
         s1_base_ff <= time_base_in;
         s1_count_ff <= sample_count_in;
      end
   end

   // stage 2: partial products
   localparam int PLO_W = 32 + tsbt_pkg::NS_PER_SAMPLE_W;
   localparam int LPW = tsbt_pkg::LEAD_PROD_W;

   logic [PLO_W-1:0] p_lo_in;
   logic [PLO_W-1:0] p_hi_full;
   logic [31:0] p_hi_in;
   logic signed [tsbt_pkg::LEAD_SUM_W-1:0] lead_sum;
   logic signed [LPW-1:0] lead_prod_in;

   always_comb begin
      p_lo_in = PLO_W'(s1_count_ff[31:0]) * PLO_W'(cfg.ns_per_sample);
      p_hi_full = PLO_W'(s1_count_ff[63:32]) * PLO_W'(cfg.ns_per_sample);
      p_hi_in = p_hi_full[31:0];
      lead_sum = $signed({2'b00, cfg.cach_lead_samples})
         + $signed({{2{cfg.correction_samples[tsbt_pkg::CORRECTION_W-1]}},
                    cfg.correction_samples});
      lead_prod_in = LPW'(lead_sum) * $signed(LPW'({1'b0, cfg.ns_per_sample}));
   end

   logic [2:0] s2_mode_ff;
   logic [1:0] s2_slot_ff;
   logic s2_bit_ff;
   logic [63:0] s2_base_ff;
   logic [PLO_W-1:0] s2_p_lo_ff;
   logic [31:0] s2_p_hi_ff;
   logic signed [LPW-1:0] s2_lead_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en_s2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_s2 && s1_valid_ff) begin
         s2_mode_ff <= s1_mode_ff;
         s2_slot_ff <= s1_slot_ff;
         s2_bit_ff <= s1_bit_ff;
         s2_base_ff <= s1_base_ff;
         s2_p_lo_ff <= p_lo_in;
         s2_p_hi_ff <= p_hi_in;
         s2_lead_ff <= lead_prod_in;
      end
   end

   // stage 3: time sum, slot captures, burst schedule
   logic [63:0] slot_capture_ff [tsbt_pkg::NUM_SLOTS];
   logic [63:0] next_burst_ff, next_burst_in;
   logic tx_flag_ff, tx_flag_in;
   logic first_pending_ff, first_pending_in;

   logic commit;
   logic [63:0] now_time;
   logic slot_ok;
   logic [tsbt_pkg::SLOT_IDX_W-1:0] slot_idx;
   logic [31:0] slot_x3;
   logic [31:0] slot_x2;
   logic [63:0] lead_ext;
   logic capture_we;
   tsbt_pkg::rsp_type rsp_in;

   assign commit = en_out && s2_valid_ff;

   always_comb begin
      now_time = s2_base_ff + 64'(s2_p_lo_ff) + {s2_p_hi_ff, 32'd0};
      slot_ok = (s2_slot_ff == 2'd1) || (s2_slot_ff == 2'd2);
      // slot 1 -> entry 0, slot 2 -> entry 1
      slot_idx = s2_slot_ff[1];
      slot_x3 = 32'(cfg.slot_length_ns) + {1'b0, cfg.slot_length_ns, 1'b0};
      slot_x2 = {1'b0, cfg.slot_length_ns, 1'b0};
      lead_ext = {{(64-LPW){s2_lead_ff[LPW-1]}}, s2_lead_ff};

      next_burst_in = next_burst_ff;
      tx_flag_in = tx_flag_ff;
      first_pending_in = first_pending_ff;
      capture_we = 1'b0;

      rsp_in.current_time = now_time;
      rsp_in.burst_time = 64'd0;
      rsp_in.slot_synced = 1'b0;
      rsp_in.ready_slot = 2'd0;

      case (s2_mode_ff)
         tsbt_pkg::MODE_CAPTURE: begin
            if (slot_ok) begin
               capture_we = 1'b1;
               if (!tx_flag_ff && !cfg.direct_mode) begin
                  rsp_in.slot_synced = 1'b1;
                  rsp_in.ready_slot = s2_slot_ff;
               end
            end
         end
         tsbt_pkg::MODE_REQUEST: begin
            if (!tx_flag_ff || !slot_ok) begin
               tx_flag_in = 1'b0;
               first_pending_in = 1'b0;
            end else begin
               if (first_pending_ff) begin
                  next_burst_in = slot_capture_ff[slot_idx] + 64'(slot_x3) + lead_ext;
                  first_pending_in = 1'b0;
               end else begin
                  next_burst_in = next_burst_ff + 64'(slot_x2);
               end
               rsp_in.burst_time = next_burst_in;
            end
         end
         tsbt_pkg::MODE_TRANSMIT: begin
            tx_flag_in = s2_bit_ff;
            first_pending_in = s2_bit_ff;
         end
         default: ;
      endcase

      rsp_in.transmit_on = tx_flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         tx_flag_ff <= 1'b0;
         first_pending_ff <= 1'b0;
         next_burst_ff <= 64'd0;
         for (int i = 0; i < tsbt_pkg::NUM_SLOTS; i++) begin
            slot_capture_ff[i] <= 64'd0;
         end
      end else begin
         if (en_out) begin
            rsp_valid_ff <= s2_valid_ff;
         end
         if (commit) begin
            tx_flag_ff <= tx_flag_in;
            first_pending_ff <= first_pending_in;
            next_burst_ff <= next_burst_in;
            if (capture_we) begin
               slot_capture_ff[slot_idx] <= now_time;
            end
         end
      end
   end

   tsbt_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule
